>>> sv/xet_pkg.sv
// Shared types, constants and helpers for the XML element tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package xet_pkg;

   localparam int BLANK_DEPTH = 32;
   localparam int CNT_W       = $clog2(BLANK_DEPTH + 1);
   localparam int ADDR_W      = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_EOS  = 1'b1;

   localparam logic [1:0] RK_CONTENT = 2'd0;
   localparam logic [1:0] RK_ELEMENT = 2'd1;
   localparam logic [1:0] RK_EOS     = 2'd2;

   localparam logic [1:0] EK_TEXT    = 2'd0;
   localparam logic [1:0] EK_TAG     = 2'd1;
   localparam logic [1:0] EK_DECL    = 2'd2;
   localparam logic [1:0] EK_COMMENT = 2'd3;

   typedef enum logic [3:0] {
      M_IDLE, M_LT, M_TAG, M_DECL, M_SKIP, M_BANG1, M_BANG2, M_COMMENT, M_DASH1, M_DASH2
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] record_kind;
      logic [1:0] element_kind;
      logic       is_start;
      logic       is_end;
      logic       ws_lost;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic emit_blank;
      logic emit_tail;
      logic emit_held;
      logic emit_cur;
      logic emit_eof;
   } cmd_type;

   typedef struct packed {
      logic plan_flush;
      logic plan_dash;
      logic plan_eof;
      logic flush_last;
      logic rsp_free;
   } stat_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
             (b == 8'h0C) || (b == 8'h0D);
   endfunction

endpackage
`default_nettype wire

>>> sv/xet_if.sv
// Request and response channel interfaces of the XML element tokenizer.
`timescale 1ns / 1ps
`default_nettype none
interface xet_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink (input valid, input action, input in_byte, output ready);
endinterface

interface xet_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] record_kind;
   logic [1:0] element_kind;
   logic       is_start;
   logic       is_end;
   logic       ws_lost;
   logic       last;

   modport source (output valid, output out_byte, output record_kind, output element_kind,
                   output is_start, output is_end, output ws_lost, output last, input ready);
   modport sink (input valid, input out_byte, input record_kind, input element_kind,
                 input is_start, input is_end, input ws_lost, input last, output ready);
endinterface
`default_nettype wire

>>> sv/xet_ctrl.sv
// Sequencer that accepts beats and steps through multi-result emissions.
`timescale 1ns / 1ps
`default_nettype none
module xet_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  xet_pkg::stat_type   stat,
   output xet_pkg::cmd_type    cmd
);
   import xet_pkg::*;

   typedef enum logic [2:0] {
      ST_ACCEPT, ST_FLUSH_RD, ST_FLUSH_EMIT, ST_TAIL, ST_HELD, ST_CUR, ST_EOF
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_ACCEPT: begin
            req_ready = stat.rsp_free;
            if (req_valid && stat.rsp_free) begin
               cmd.accept = 1'b1;
               if (stat.plan_flush) begin
                  state_in = ST_FLUSH_RD;
               end else if (stat.plan_dash) begin
                  state_in = ST_HELD;
               end else if (stat.plan_eof) begin
                  state_in = ST_EOF;
               end
            end
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH_EMIT;
         end
         ST_FLUSH_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit_blank = 1'b1;
               state_in = stat.flush_last ? ST_TAIL : ST_FLUSH_RD;
            end
         end
         ST_TAIL: begin
            if (stat.rsp_free) begin
               cmd.emit_tail = 1'b1;
               state_in = ST_ACCEPT;
            end
         end
         ST_HELD: begin
            if (stat.rsp_free) begin
               cmd.emit_held = 1'b1;
               state_in = ST_CUR;
            end
         end
         ST_CUR: begin
            if (stat.rsp_free) begin
               cmd.emit_cur = 1'b1;
               state_in = ST_ACCEPT;
            end
         end
         ST_EOF: begin
            if (stat.rsp_free) begin
               cmd.emit_eof = 1'b1;
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/xet_dp.sv
// Parse state, pending blank buffer and response register.
`timescale 1ns / 1ps
`default_nettype none
module xet_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_action,
   input  wire  [7:0]          req_in_byte,
   input  wire                 rsp_ready,
   output logic                rsp_valid,
   output xet_pkg::rsp_type    rsp_data,
   input  xet_pkg::cmd_type    cmd,
   output xet_pkg::stat_type   stat
);
   import xet_pkg::*;

   logic [7:0] blank_mem [BLANK_DEPTH];

   mode_type          mode_ff, mode_in;
   logic              start_ff, start_in;
   logic              end_ff, end_in;
   logic              text_ff, text_in;
   logic [7:0]        held_ff, held_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [7:0]        cur_ff, cur_in;
   logic              lost_ff, lost_in;
   logic [CNT_W-1:0]  ptr_ff;
   logic [7:0]        rd_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              wr_en;
   logic              r0_valid;
   rsp_type           r0;
   logic              plan_flush, plan_dash, plan_eof;
   logic              load;
   rsp_type           load_data;

   function automatic rsp_type content(input logic [7:0] b, input logic [1:0] ek,
                                       input logic lost, input logic lst);
      rsp_type r;
      r              = '0;
      r.out_byte     = b;
      r.record_kind  = RK_CONTENT;
      r.element_kind = ek;
      r.ws_lost      = lost;
      r.last         = lst;
      return r;
   endfunction

   function automatic rsp_type element(input logic [1:0] ek, input logic s, input logic e,
                                       input logic lst);
      rsp_type r;
      r              = '0;
      r.record_kind  = RK_ELEMENT;
      r.element_kind = ek;
      r.is_start     = s;
      r.is_end       = e;
      r.last         = lst;
      return r;
   endfunction

   // Effect of the beat offered on the request channel.
   always_comb begin
      mode_in    = mode_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      text_in    = text_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      cur_in     = cur_ff;
      lost_in    = lost_ff;
      wr_en      = 1'b0;
      r0_valid   = 1'b0;
      r0         = '0;
      plan_flush = 1'b0;
      plan_dash  = 1'b0;
      plan_eof   = 1'b0;
      if (req_action == ACT_EOS) begin
         r0_valid = 1'b1;
         if (mode_ff == M_IDLE && text_ff) begin
            r0       = element(EK_TEXT, 1'b1, 1'b1, 1'b0);
            plan_eof = 1'b1;
         end else begin
            r0.record_kind = RK_EOS;
            r0.last        = 1'b1;
         end
         mode_in  = M_IDLE;
         start_in = 1'b0;
         end_in   = 1'b0;
         held_in  = '0;
         text_in  = 1'b0;
         count_in = '0;
         drop_in  = 1'b0;
      end else begin
         case (mode_ff)
            M_LT: begin
               if (req_in_byte == CH_QMARK) begin
                  mode_in = M_DECL;
               end else if (req_in_byte == CH_BANG) begin
                  mode_in = M_BANG1;
               end else if (req_in_byte == CH_SLASH) begin
                  start_in = 1'b0;
                  end_in   = 1'b1;
                  mode_in  = M_TAG;
               end else if (req_in_byte == CH_GT) begin
                  r0_valid = 1'b1;
                  r0       = element(EK_TAG, 1'b1, 1'b0, 1'b1);
                  start_in = 1'b0;
                  end_in   = 1'b0;
                  mode_in  = M_IDLE;
               end else begin
                  r0_valid = 1'b1;
                  r0       = content(req_in_byte, EK_TAG, 1'b0, 1'b1);
                  start_in = 1'b1;
                  end_in   = 1'b0;
                  mode_in  = M_TAG;
               end
            end
            M_TAG: begin
               if (req_in_byte == CH_SLASH) begin
                  end_in = 1'b1;
               end else if (req_in_byte == CH_GT) begin
                  r0_valid = 1'b1;
                  r0       = element(EK_TAG, start_ff, end_ff, 1'b1);
                  start_in = 1'b0;
                  end_in   = 1'b0;
                  mode_in  = M_IDLE;
               end else begin
                  r0_valid = 1'b1;
                  r0       = content(req_in_byte, EK_TAG, 1'b0, 1'b1);
               end
            end
            M_DECL: begin
               r0_valid = 1'b1;
               if (req_in_byte == CH_QMARK) begin
                  r0      = element(EK_DECL, 1'b1, 1'b1, 1'b1);
                  mode_in = M_SKIP;
               end else begin
                  r0 = content(req_in_byte, EK_DECL, 1'b0, 1'b1);
               end
            end
            M_SKIP: begin
               mode_in = M_IDLE;
            end
            M_BANG1: begin
               mode_in = M_BANG2;
            end
            M_BANG2: begin
               mode_in = M_COMMENT;
            end
            M_COMMENT: begin
               if (req_in_byte == CH_DASH) begin
                  mode_in = M_DASH1;
               end else begin
                  r0_valid = 1'b1;
                  r0       = content(req_in_byte, EK_COMMENT, 1'b0, 1'b1);
               end
            end
            M_DASH1: begin
               held_in = req_in_byte;
               mode_in = M_DASH2;
            end
            M_DASH2: begin
               r0_valid = 1'b1;
               if (held_ff == CH_DASH && req_in_byte == CH_GT) begin
                  r0      = element(EK_COMMENT, 1'b1, 1'b1, 1'b1);
                  mode_in = M_IDLE;
               end else begin
                  r0        = content(CH_DASH, EK_COMMENT, 1'b0, 1'b0);
                  cur_in    = req_in_byte;
                  plan_dash = 1'b1;
                  mode_in   = M_COMMENT;
               end
            end
            default: begin
               mode_in = M_IDLE;
               if (req_in_byte == CH_LT) begin
                  if (text_ff) begin
                     r0_valid = 1'b1;
                     r0       = element(EK_TEXT, 1'b1, 1'b1, 1'b1);
                  end
                  text_in  = 1'b0;
                  count_in = '0;
                  drop_in  = 1'b0;
                  mode_in  = M_LT;
               end else if (is_blank(req_in_byte)) begin
                  if (text_ff) begin
                     if (count_ff < CNT_W'(BLANK_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
               end else begin
                  text_in = 1'b1;
                  drop_in = 1'b0;
                  if (count_ff != '0) begin
                     cur_in     = req_in_byte;
                     lost_in    = drop_ff;
                     plan_flush = 1'b1;
                  end else begin
                     r0_valid = 1'b1;
                     r0       = content(req_in_byte, EK_TEXT, drop_ff, 1'b1);
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      load      = 1'b1;
      load_data = '0;
      if (cmd.accept) begin
         load      = r0_valid;
         load_data = r0;
      end else if (cmd.emit_blank) begin
         load_data = content(rd_data_ff, EK_TEXT, lost_ff, 1'b0);
      end else if (cmd.emit_tail) begin
         load_data = content(cur_ff, EK_TEXT, lost_ff, 1'b1);
      end else if (cmd.emit_held) begin
         load_data = content(held_ff, EK_COMMENT, 1'b0, 1'b0);
      end else if (cmd.emit_cur) begin
         load_data = content(cur_ff, EK_COMMENT, 1'b0, 1'b1);
      end else if (cmd.emit_eof) begin
         load_data.record_kind = RK_EOS;
         load_data.last        = 1'b1;
      end else begin
         load = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         blank_mem[count_ff[ADDR_W-1:0]] <= req_in_byte;
      end
      rd_data_ff <= blank_mem[ptr_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_IDLE;
         start_ff     <= 1'b0;
         end_ff       <= 1'b0;
         text_ff      <= 1'b0;
         held_ff      <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         lost_ff      <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            end_ff   <= end_in;
            text_ff  <= text_in;
            held_ff  <= held_in;
            count_ff <= count_in;
            drop_ff  <= drop_in;
            lost_ff  <= lost_in;
            ptr_ff   <= '0;
         end else if (cmd.emit_blank) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end else if (cmd.emit_tail) begin
            count_ff <= '0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff <= cur_in;
      end
      if (load) begin
         rsp_ff <= load_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign stat.plan_flush = plan_flush;
   assign stat.plan_dash  = plan_dash;
   assign stat.plan_eof   = plan_eof;
   assign stat.flush_last = (CNT_W'(ptr_ff + CNT_W'(1)) == count_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BLANK_DEPTH))
      else $error("pending blank count beyond buffer depth");

   a_flush_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_blank |-> (ptr_ff < count_ff))
      else $error("flush read beyond pending blanks");

   a_tail_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_tail |=> (count_ff == '0) && text_ff)
      else $error("pending blanks left after flush");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

endmodule
`default_nettype wire

>>> sv/xml_element_tokenizer.sv
// Top level of the streaming XML element tokenizer.
// The first result is registered at the accept edge, or in ST_FLUSH_EMIT when blanks flush.
// Throughput: one beat per cycle when a beat has at most one result and no response stalls;
// a comment dash mismatch adds ST_HELD and ST_CUR, end of stream after text adds ST_EOF;
// each buffered blank adds ST_FLUSH_RD (registered read) and ST_FLUSH_EMIT, then ST_TAIL.
// Reset: synchronous, clears the parse state; the blank buffer needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module xml_element_tokenizer (
   input wire        clock,
   input wire        reset,
   xet_req_if.sink   req_bus,
   xet_rsp_if.source rsp_bus
);
   import xet_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp_data;
   logic     rsp_valid;
   logic     req_ready;

   xet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   xet_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_action  (req_bus.action),
      .req_in_byte (req_bus.in_byte),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .stat        (stat)
   );

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.out_byte     = rsp_data.out_byte;
   assign rsp_bus.record_kind  = rsp_data.record_kind;
   assign rsp_bus.element_kind = rsp_data.element_kind;
   assign rsp_bus.is_start     = rsp_data.is_start;
   assign rsp_bus.is_end       = rsp_data.is_end;
   assign rsp_bus.ws_lost      = rsp_data.ws_lost;
   assign rsp_bus.last         = rsp_data.last;

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the XML element tokenizer: random byte streams against a predictor.
`timescale 1ns / 1ps
module testbench;
   import xet_pkg::*;

   localparam int RUN_LIMIT   = 1000000;
   localparam int DRAIN_WAIT  = 80;
   localparam int STREAM_SIZE = 360;

   typedef struct {
      logic       act;
      logic [7:0] data;
      int         gap;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xet_req_if req_bus ();
   xet_rsp_if rsp_bus ();

   xml_element_tokenizer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   beat_type beats_pending[$];
   beat_type next_beat;
   rsp_type  tokens_due[$];
   rsp_type  step_tokens[$];
   rsp_type  rsp_seen;

   int  beats_in, beats_out, beats_offered, rsp_taken, items_total;
   int  req_gap, rsp_stall, errors, cycles;
   int  n_text, n_tag, n_decl, n_comment, n_eos, n_lost;
   bit  sender_calm, rsp_calm, hold_rsp;

   mode_type   tok_mode = M_IDLE;
   logic       tag_opens = 1'b0;
   logic       tag_closes = 1'b0;
   logic       text_open = 1'b0;
   logic       blank_lost = 1'b0;
   logic [7:0] dash_byte = 8'h00;
   logic [7:0] blank_buf[BLANK_DEPTH];
   int         blank_cnt = 0;

   function automatic bit blank_char(input logic [7:0] c);
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void emit_token(input logic [7:0] b, input logic [1:0] rk,
                                      input logic [1:0] ek, input logic s, input logic e,
                                      input logic lost);
      rsp_type t;
      t.out_byte     = b;
      t.record_kind  = rk;
      t.element_kind = ek;
      t.is_start     = s;
      t.is_end       = e;
      t.ws_lost      = lost;
      t.last         = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void tag_content(input logic [7:0] b);
      if (b == CH_SLASH) begin
         tag_closes = 1'b1;
      end else if (b == CH_GT) begin
         emit_token(8'h00, RK_ELEMENT, EK_TAG, tag_opens, tag_closes, 1'b0);
         tag_opens  = 1'b0;
         tag_closes = 1'b0;
         tok_mode   = M_IDLE;
      end else begin
         emit_token(b, RK_CONTENT, EK_TAG, 1'b0, 1'b0, 1'b0);
      end
   endfunction

   function automatic void tokenize_beat(input logic act, input logic [7:0] b);
      rsp_type t;
      step_tokens.delete();
      if (act == ACT_EOS) begin
         if (tok_mode == M_IDLE && text_open)
            emit_token(8'h00, RK_ELEMENT, EK_TEXT, 1'b1, 1'b1, 1'b0);
         emit_token(8'h00, RK_EOS, EK_TEXT, 1'b0, 1'b0, 1'b0);
         tok_mode   = M_IDLE;
         tag_opens  = 1'b0;
         tag_closes = 1'b0;
         dash_byte  = 8'h00;
         text_open  = 1'b0;
         blank_cnt  = 0;
         blank_lost = 1'b0;
      end else begin
         case (tok_mode)
            M_LT: begin
               if (b == CH_QMARK) begin
                  tok_mode = M_DECL;
               end else if (b == CH_BANG) begin
                  tok_mode = M_BANG1;
               end else if (b == CH_SLASH) begin
                  tag_opens  = 1'b0;
                  tag_closes = 1'b1;
                  tok_mode   = M_TAG;
               end else begin
                  tag_opens  = 1'b1;
                  tag_closes = 1'b0;
                  tok_mode   = M_TAG;
                  tag_content(b);
               end
            end
            M_TAG: tag_content(b);
            M_DECL: begin
               if (b == CH_QMARK) begin
                  emit_token(8'h00, RK_ELEMENT, EK_DECL, 1'b1, 1'b1, 1'b0);
                  tok_mode = M_SKIP;
               end else begin
                  emit_token(b, RK_CONTENT, EK_DECL, 1'b0, 1'b0, 1'b0);
               end
            end
            M_SKIP:  tok_mode = M_IDLE;
            M_BANG1: tok_mode = M_BANG2;
            M_BANG2: tok_mode = M_COMMENT;
            M_COMMENT: begin
               if (b == CH_DASH)
                  tok_mode = M_DASH1;
               else
                  emit_token(b, RK_CONTENT, EK_COMMENT, 1'b0, 1'b0, 1'b0);
            end
            M_DASH1: begin
               dash_byte = b;
               tok_mode  = M_DASH2;
            end
            M_DASH2: begin
               if (dash_byte == CH_DASH && b == CH_GT) begin
                  emit_token(8'h00, RK_ELEMENT, EK_COMMENT, 1'b1, 1'b1, 1'b0);
                  tok_mode = M_IDLE;
               end else begin
                  emit_token(CH_DASH, RK_CONTENT, EK_COMMENT, 1'b0, 1'b0, 1'b0);
                  emit_token(dash_byte, RK_CONTENT, EK_COMMENT, 1'b0, 1'b0, 1'b0);
                  emit_token(b, RK_CONTENT, EK_COMMENT, 1'b0, 1'b0, 1'b0);
                  tok_mode = M_COMMENT;
               end
            end
            default: begin
               tok_mode = M_IDLE;
               if (b == CH_LT) begin
                  if (text_open)
                     emit_token(8'h00, RK_ELEMENT, EK_TEXT, 1'b1, 1'b1, 1'b0);
                  text_open  = 1'b0;
                  blank_cnt  = 0;
                  blank_lost = 1'b0;
                  tok_mode   = M_LT;
               end else if (blank_char(b)) begin
                  if (text_open) begin
                     if (blank_cnt < BLANK_DEPTH) begin
                        blank_buf[blank_cnt] = b;
                        blank_cnt++;
                     end else begin
                        blank_lost = 1'b1;
                     end
                  end
               end else begin
                  for (int k = 0; k < blank_cnt; k++)
                     emit_token(blank_buf[k], RK_CONTENT, EK_TEXT, 1'b0, 1'b0, blank_lost);
                  emit_token(b, RK_CONTENT, EK_TEXT, 1'b0, 1'b0, blank_lost);
                  blank_cnt  = 0;
                  blank_lost = 1'b0;
                  text_open  = 1'b1;
               end
            end
         endcase
      end
      foreach (step_tokens[k]) begin
         t      = step_tokens[k];
         t.last = (k == step_tokens.size() - 1);
         tokens_due.push_back(t);
      end
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
   endfunction

   function automatic void check_token(input rsp_type got);
      rsp_type want;
      if (tokens_due.size() == 0) begin
         $display("%0t ns: result with none expected, got byte %0h kind %0d", $time,
                  got.out_byte, got.record_kind);
         errors++;
      end else begin
         want = tokens_due.pop_front();
         if (got.out_byte !== want.out_byte)
            note_mismatch("out_byte", want.out_byte, got.out_byte);
         if (got.record_kind !== want.record_kind)
            note_mismatch("record_kind", want.record_kind, got.record_kind);
         if (got.element_kind !== want.element_kind)
            note_mismatch("element_kind", want.element_kind, got.element_kind);
         if (got.is_start !== want.is_start)
            note_mismatch("is_start", want.is_start, got.is_start);
         if (got.is_end !== want.is_end)
            note_mismatch("is_end", want.is_end, got.is_end);
         if (got.ws_lost !== want.ws_lost)
            note_mismatch("ws_lost", want.ws_lost, got.ws_lost);
         if (got.last !== want.last)
            note_mismatch("last", want.last, got.last);
      end
   endfunction

   function automatic void queue_beat(input logic act, input logic [7:0] data);
      beat_type it;
      it.act  = act;
      it.data = data;
      it.gap  = sender_calm ? 0 : $urandom_range(0, 13);
      beats_pending.push_back(it);
   endfunction

   function automatic logic [7:0] rand_except(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
      return c;
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_LT || blank_char(c));
      return c;
   endfunction

   function automatic logic [7:0] blank_pick();
      case ($urandom_range(0, 5))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0A;
         3: return 8'h0B;
         4: return 8'h0C;
         default: return 8'h0D;
      endcase
   endfunction

   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || beats_in == beats_offered)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (beats_pending.size() > 0) begin
            next_beat = beats_pending.pop_front();
            req_bus.action  <= next_beat.act;
            req_bus.in_byte <= next_beat.data;
            req_bus.valid   <= 1'b1;
            beats_offered++;
            req_gap = next_beat.gap;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (beats_out != rsp_taken) begin
         rsp_taken = beats_out;
         if ($urandom_range(0, 49) == 0)
            rsp_calm = !rsp_calm;
         rsp_stall = rsp_calm ? 0 : $urandom_range(0, 13);
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !hold_rsp;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tokenize_beat(req_bus.action, req_bus.in_byte);
            beats_in++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen.out_byte     = rsp_bus.out_byte;
            rsp_seen.record_kind  = rsp_bus.record_kind;
            rsp_seen.element_kind = rsp_bus.element_kind;
            rsp_seen.is_start     = rsp_bus.is_start;
            rsp_seen.is_end       = rsp_bus.is_end;
            rsp_seen.ws_lost      = rsp_bus.ws_lost;
            rsp_seen.last         = rsp_bus.last;
            check_token(rsp_seen);
            beats_out++;
            if (rsp_seen.ws_lost)
               n_lost++;
            if (rsp_seen.record_kind == RK_EOS)
               n_eos++;
            else if (rsp_seen.record_kind == RK_ELEMENT)
               case (rsp_seen.element_kind)
                  EK_TEXT: n_text++;
                  EK_TAG:  n_tag++;
                  EK_DECL: n_decl++;
                  default: n_comment++;
               endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycles,
                  tokens_due.size());
         $display("testbench failed");
         $finish;
      end
   end

   // stall the response side long enough to back up into the request side
   initial begin
      hold_rsp = 1'b0;
      while (beats_in < 120) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int n, m;
      logic [7:0] x;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_DATA;
      req_bus.in_byte = 8'h00;
      rsp_bus.ready   = 1'b0;

      queue_beat(ACT_DATA, 8'h20);
      queue_beat(ACT_DATA, "a");
      queue_beat(ACT_DATA, 8'h09);
      queue_beat(ACT_DATA, 8'h00);
      queue_beat(ACT_DATA, CH_GT);
      queue_beat(ACT_DATA, CH_LT);
      queue_beat(ACT_DATA, CH_SLASH);
      queue_beat(ACT_DATA, 8'hFF);
      queue_beat(ACT_DATA, CH_GT);
      queue_beat(ACT_DATA, CH_LT);
      queue_beat(ACT_DATA, CH_QMARK);
      queue_beat(ACT_DATA, "x");
      queue_beat(ACT_DATA, CH_QMARK);
      queue_beat(ACT_DATA, CH_LT);
      queue_beat(ACT_DATA, CH_LT);
      queue_beat(ACT_DATA, CH_BANG);
      queue_beat(ACT_DATA, CH_DASH);
      queue_beat(ACT_DATA, CH_DASH);
      queue_beat(ACT_DATA, CH_DASH);
      queue_beat(ACT_DATA, "q");
      queue_beat(ACT_DATA, "r");
      queue_beat(ACT_DATA, CH_DASH);
      queue_beat(ACT_DATA, CH_DASH);
      queue_beat(ACT_DATA, CH_GT);
      queue_beat(ACT_DATA, CH_LT);
      queue_beat(ACT_DATA, "p");
      queue_beat(ACT_EOS, 8'hFF);
      queue_beat(ACT_DATA, "z");
      queue_beat(ACT_EOS, 8'h00);

      while (beats_pending.size() < STREAM_SIZE) begin
         if ($urandom_range(0, 7) == 0)
            sender_calm = !sender_calm;
         case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
               queue_beat(ACT_DATA, text_char());
               m = $urandom_range(0, 5);
               for (int i = 0; i < m; i++) begin
                  n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                                  : $urandom_range(0, 3);
                  for (int j = 0; j < n; j++)
                     queue_beat(ACT_DATA, blank_pick());
                  queue_beat(ACT_DATA, text_char());
               end
               n = $urandom_range(0, 3);
               for (int j = 0; j < n; j++)
                  queue_beat(ACT_DATA, blank_pick());
            end
            4, 5, 6: begin
               queue_beat(ACT_DATA, CH_LT);
               if ($urandom_range(0, 2) == 0)
                  queue_beat(ACT_DATA, CH_SLASH);
               queue_beat(ACT_DATA, rand_except(CH_QMARK, CH_BANG));
               n = $urandom_range(0, 4);
               for (int j = 0; j < n; j++)
                  queue_beat(ACT_DATA, rand_except(CH_GT, CH_GT));
               if ($urandom_range(0, 7) != 0)
                  queue_beat(ACT_DATA, CH_GT);
            end
            7: begin
               queue_beat(ACT_DATA, CH_LT);
               queue_beat(ACT_DATA, CH_QMARK);
               n = $urandom_range(0, 4);
               for (int j = 0; j < n; j++)
                  queue_beat(ACT_DATA, rand_except(CH_QMARK, CH_QMARK));
               queue_beat(ACT_DATA, CH_QMARK);
               queue_beat(ACT_DATA, 8'($urandom_range(0, 255)));
            end
            8, 9: begin
               queue_beat(ACT_DATA, CH_LT);
               queue_beat(ACT_DATA, CH_BANG);
               queue_beat(ACT_DATA, 8'($urandom_range(0, 255)));
               queue_beat(ACT_DATA, 8'($urandom_range(0, 255)));
               n = $urandom_range(0, 4);
               for (int j = 0; j < n; j++) begin
                  if ($urandom_range(0, 2) == 0) begin
                     x = 8'($urandom_range(0, 255));
                     queue_beat(ACT_DATA, CH_DASH);
                     queue_beat(ACT_DATA, x);
                     queue_beat(ACT_DATA, (x == CH_DASH) ? rand_except(CH_GT, CH_GT)
                                                         : 8'($urandom_range(0, 255)));
                  end else begin
                     queue_beat(ACT_DATA, rand_except(CH_DASH, CH_DASH));
                  end
               end
               queue_beat(ACT_DATA, CH_DASH);
               queue_beat(ACT_DATA, CH_DASH);
               queue_beat(ACT_DATA, CH_GT);
            end
            10: begin
               n = $urandom_range(1, 4);
               for (int j = 0; j < n; j++)
                  queue_beat(ACT_DATA, 8'($urandom_range(0, 255)));
            end
            default: queue_beat(ACT_EOS, 8'($urandom_range(0, 255)));
         endcase
      end
      queue_beat(ACT_EOS, 8'($urandom_range(0, 255)));
      items_total = beats_pending.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_in < items_total) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d input beats gave %0d results: %0d text, %0d tag, %0d declaration,",
               beats_in, beats_out, n_text, n_tag, n_decl);
      $display("%0d comment and %0d end-of-stream records; %0d results after dropped blanks",
               n_comment, n_eos, n_lost);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
